### rtl/crdf_pkg.sv
package crdf_pkg;

  localparam int unsigned IdW      = 29;
  localparam int unsigned PayloadW = 64;
  localparam int unsigned StampW   = 16;
  localparam int unsigned OutDataW = 120;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_HDR1  = 4'd1,
    PH_SL    = 4'd2,
    PH_DID   = 4'd3,
    PH_DTS   = 4'd4,
    PH_DPAY  = 4'd5,
    PH_SF    = 4'd6,
    PH_SN    = 4'd7,
    PH_STS   = 4'd8,
    PH_SBODY = 4'd9
  } crdf_phase_e;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_STATE    = 2'd1,
    KIND_OVERFLOW = 2'd2,
    KIND_FMT_ERR  = 2'd3
  } crdf_kind_e;

  typedef enum logic [1:0] {
    BUS_ACTIVE  = 2'd0,
    BUS_WARNING = 2'd1,
    BUS_PASSIVE = 2'd2,
    BUS_OFF     = 2'd3
  } crdf_bus_e;

  typedef struct packed {
    crdf_phase_e           phase;
    logic [3:0]            field_count;
    logic [7:0]            records_total;
    logic [7:0]            record_index;
    logic                  data_seen;
    logic [7:0]            status_latch;
    logic [7:0]            func_code;
    logic [7:0]            func_arg;
    logic [StampW-1:0]     stamp;
    logic [7:0]            prev_low;
    logic [31:0]           id_accum;
    logic [PayloadW-1:0]   payload;
    crdf_bus_e             err;
    logic                  synced;
  } crdf_state_t;

  typedef struct packed {
    crdf_kind_e            kind;
    logic [IdW-1:0]        frame_id;
    logic                  is_extended;
    logic                  is_remote;
    logic [3:0]            data_length;
    logic [PayloadW-1:0]   payload;
    logic [StampW-1:0]     stamp;
    logic                  stamp_valid;
    crdf_bus_e             bus_state;
  } crdf_result_t;

endpackage

### rtl/can_usb_rx_record_deframer.sv
// channel   dir  tdata                     tuser             tlast
// s_axis    in   [7:0] buffer byte         first byte flag   last byte of buffer
// m_axis    out  [119:0] record fields     [1:0] record kind -
//
// One byte per clock while s_axis_tready_o is high: each accepted byte is decoded in the same cycle against
// the parser registers and any result lands in a two-entry output register.
// s_axis_tready_o drops only while both output entries hold unread results.
// Reset clears the parser to wait for a buffer start with the bus error-active.
// Results leave in order through the main and skid output entries.
module can_usb_rx_record_deframer import crdf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [7:0]          s_axis_tdata_i,   // in_byte
  input  logic                s_axis_tuser_i,   // first_byte
  input  logic                s_axis_tlast_i,   // last_byte
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // frame_id[28:0], is_extended[29], is_remote[30], data_length[34:31],
  // payload[98:35], stamp[114:99], stamp_valid[115], bus_state[117:116], zero pad
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic [1:0]          m_axis_tuser_o    // record_kind
);

  crdf_state_t  state_q, state_d;
  crdf_result_t step_res;
  crdf_result_t out_res;
  logic         step_valid;
  logic         accept;
  logic         q_full;

  assign s_axis_tready_o = !q_full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  crdf_step u_step (
    .byte_i      (s_axis_tdata_i),
    .first_i     (s_axis_tuser_i),
    .last_i      (s_axis_tlast_i),
    .state_i     (state_q),
    .state_o     (state_d),
    .res_valid_o (step_valid),
    .res_o       (step_res)
  );

  // all-zero state is idle phase with the bus error-active
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  crdf_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept && step_valid),
    .data_i  (step_res),
    .full_o  (q_full),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (out_res)
  );

  assign m_axis_tuser_o = out_res.kind;
  assign m_axis_tdata_o = {2'b00, out_res.bus_state, out_res.stamp_valid, out_res.stamp,
                           out_res.payload, out_res.data_length, out_res.is_remote,
                           out_res.is_extended, out_res.frame_id};

endmodule

### rtl/crdf_step.sv
module crdf_step import crdf_pkg::*; (
  input  logic [7:0]   byte_i,
  input  logic         first_i,
  input  logic         last_i,
  input  crdf_state_t  state_i,
  output crdf_state_t  state_o,
  output logic         res_valid_o,
  output crdf_result_t res_o
);

  localparam logic [7:0] FnBusEvent = 8'd1;
  localparam logic [7:0] FnSkip2    = 8'd2;
  localparam logic [7:0] FnSkip1    = 8'd3;
  localparam logic [7:0] FnStamp    = 8'd4;

  localparam int unsigned SlTs  = 7;
  localparam int unsigned SlInt = 6;
  localparam int unsigned SlExt = 5;
  localparam int unsigned SlRtr = 4;

  typedef struct packed {
    logic       ev;
    crdf_kind_e kind;
    crdf_bus_e  nw;
  } bus_ev_t;

  function automatic bus_ev_t bus_event(logic [7:0] n, crdf_bus_e cur, logic synced);
    bus_ev_t r;
    logic    over;
    logic    silent;
    r.ev   = 1'b0;
    r.kind = KIND_STATE;
    r.nw   = cur;
    over   = 1'b0;
    silent = 1'b0;
    if ((n == 8'h40 && !synced) || cur == BUS_OFF) begin
      silent = 1'b1;
    end else if (cur == BUS_ACTIVE && n[2]) begin
      r.nw = BUS_WARNING;
    end else if (cur == BUS_ACTIVE || cur == BUS_WARNING) begin
      if (n[3]) begin
        r.nw = BUS_PASSIVE;
      end else if (n[4]) begin
        r.nw = BUS_OFF;
      end else if ((n & 8'h42) != 8'h00) begin
        over = 1'b1;
      end else if (!n[2]) begin
        r.nw   = BUS_ACTIVE;
        silent = 1'b1;
      end
    end else begin
      if (n[4]) begin
        r.nw = BUS_OFF;
      end else if (n[2]) begin
        r.nw = BUS_WARNING;
      end else if ((n & 8'h42) != 8'h00) begin
        over = 1'b1;
      end else if (!n[3]) begin
        r.nw   = BUS_ACTIVE;
        silent = 1'b1;
      end
    end
    if (over) begin
      r.ev   = 1'b1;
      r.kind = KIND_OVERFLOW;
    end else if (!silent && r.nw != cur) begin
      r.ev = 1'b1;
    end
    return r;
  endfunction

  crdf_state_t         nxt;
  logic [3:0]          sl_len;
  logic [3:0]          body_len;
  logic [3:0]          fc_inc;
  logic [7:0]          idx_inc;
  crdf_phase_e         rec_phase;
  logic                ts_wide;
  logic                ts_done;
  logic [StampW-1:0]   ts_stamp;
  logic [7:0]          ts_prev;
  logic [3:0]          ts_fc;
  logic [7:0]          ev_arg;
  bus_ev_t             bev;
  logic                head_done;
  logic                data_done;
  logic                ferr;

  assign sl_len    = state_i.status_latch[3:0];
  assign fc_inc    = state_i.field_count + 4'd1;
  assign idx_inc   = state_i.record_index + 8'd1;
  assign rec_phase = (idx_inc == state_i.records_total) ? PH_IDLE : PH_SL;

  always_comb begin
    case (state_i.func_code)
      FnSkip2: body_len = 4'd2;
      FnSkip1: body_len = 4'd1;
      FnStamp: body_len = (sl_len < 4'd2) ? 4'd2 : sl_len;
      default: body_len = sl_len;
    endcase
  end

  // timestamp byte: wide form on the first data record, or on record 0 for status, increment form after
  always_comb begin
    ts_wide  = (state_i.phase == PH_DTS) ? !state_i.data_seen
                                         : (state_i.record_index == 8'd0);
    ts_done  = 1'b1;
    ts_stamp = state_i.stamp;
    ts_prev  = state_i.prev_low;
    ts_fc    = state_i.field_count;
    if (ts_wide) begin
      if (state_i.field_count == 4'd0) begin
        ts_stamp = {state_i.stamp[15:8], byte_i};
        ts_fc    = 4'd1;
        ts_done  = 1'b0;
      end else begin
        ts_stamp = {byte_i, state_i.stamp[7:0]};
        ts_prev  = state_i.stamp[7:0];
      end
    end else begin
      if (byte_i < state_i.prev_low) begin
        ts_stamp = {state_i.stamp[15:8] + 8'd1, byte_i};
      end else begin
        ts_stamp = {state_i.stamp[15:8], byte_i};
      end
      ts_prev = byte_i;
    end
  end

  assign ev_arg = (state_i.phase == PH_SN) ? byte_i : state_i.func_arg;
  assign bev    = bus_event(ev_arg, state_i.err, state_i.synced);

  assign head_done = !first_i &&
                     ((state_i.phase == PH_SN && !state_i.status_latch[SlTs]) ||
                      (state_i.phase == PH_STS && ts_done));
  assign data_done = !first_i &&
                     ((state_i.phase == PH_DTS && ts_done &&
                       (state_i.status_latch[SlRtr] || sl_len == 4'd0)) ||
                      (state_i.phase == PH_DPAY && fc_inc == sl_len));

  // next state
  always_comb begin
    nxt = state_i;
    if (first_i) begin
      nxt.record_index = 8'd0;
      nxt.data_seen    = 1'b0;
      nxt.stamp        = '0;
      nxt.prev_low     = 8'd0;
      nxt.field_count  = 4'd0;
      nxt.phase        = PH_HDR1;
    end else begin
      case (state_i.phase)
        PH_HDR1: begin
          nxt.records_total = byte_i;
          nxt.phase         = (byte_i == 8'd0) ? PH_IDLE : PH_SL;
        end
        PH_SL: begin
          nxt.status_latch = byte_i;
          nxt.field_count  = 4'd0;
          if (byte_i[SlInt]) begin
            nxt.phase = PH_SF;
          end else begin
            nxt.id_accum = '0;
            nxt.phase    = PH_DID;
          end
        end
        PH_DID: begin
          nxt.id_accum[{state_i.field_count[1:0], 3'b000} +: 8] = byte_i;
          nxt.field_count = fc_inc;
          if (fc_inc == (state_i.status_latch[SlExt] ? 4'd4 : 4'd2)) begin
            nxt.field_count = 4'd0;
            nxt.phase       = PH_DTS;
          end
        end
        PH_DTS: begin
          nxt.stamp       = ts_stamp;
          nxt.prev_low    = ts_prev;
          nxt.field_count = ts_fc;
          if (ts_done) begin
            nxt.payload     = '0;
            nxt.field_count = 4'd0;
            if (data_done) begin
              nxt.data_seen    = 1'b1;
              nxt.record_index = idx_inc;
              nxt.phase        = rec_phase;
            end else begin
              nxt.phase = PH_DPAY;
            end
          end
        end
        PH_DPAY: begin
          if (!state_i.field_count[3]) begin
            nxt.payload[{state_i.field_count[2:0], 3'b000} +: 8] = byte_i;
          end
          nxt.field_count = fc_inc;
          if (data_done) begin
            nxt.data_seen    = 1'b1;
            nxt.record_index = idx_inc;
            nxt.phase        = rec_phase;
          end
        end
        PH_SF: begin
          nxt.func_code = byte_i;
          nxt.phase     = PH_SN;
        end
        PH_SN, PH_STS: begin
          if (state_i.phase == PH_SN) begin
            nxt.func_arg    = byte_i;
            nxt.field_count = 4'd0;
            if (state_i.status_latch[SlTs]) begin
              nxt.phase = PH_STS;
            end
          end else begin
            nxt.stamp       = ts_stamp;
            nxt.prev_low    = ts_prev;
            nxt.field_count = ts_fc;
          end
          if (head_done) begin
            if (state_i.func_code == FnBusEvent) begin
              nxt.err = bev.nw;
            end
            nxt.field_count = 4'd0;
            if (body_len == 4'd0) begin
              nxt.record_index = idx_inc;
              nxt.phase        = rec_phase;
            end else begin
              nxt.phase = PH_SBODY;
            end
          end
        end
        PH_SBODY: begin
          if (state_i.func_code == FnStamp && state_i.field_count < 4'd2) begin
            if (state_i.field_count == 4'd0) begin
              nxt.stamp = {state_i.stamp[15:8], byte_i};
            end else begin
              nxt.stamp  = {byte_i, state_i.stamp[7:0]};
              nxt.synced = 1'b1;
            end
          end
          nxt.field_count = fc_inc;
          if (fc_inc == body_len) begin
            nxt.record_index = idx_inc;
            nxt.phase        = rec_phase;
          end
        end
        default: begin
          nxt.phase = PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    state_o = nxt;
    if (last_i) begin
      state_o.phase = PH_IDLE;
    end
  end

  // result
  assign ferr = last_i && (first_i || state_i.phase == PH_HDR1 ||
                           !(nxt.phase == PH_SL || nxt.phase == PH_IDLE ||
                             nxt.phase == PH_HDR1));

  always_comb begin
    res_o           = '0;
    res_o.bus_state = nxt.err;
    res_valid_o     = 1'b0;
    if (ferr) begin
      res_valid_o = 1'b1;
      res_o.kind  = KIND_FMT_ERR;
    end else if (data_done) begin
      res_valid_o       = 1'b1;
      res_o.kind        = KIND_DATA;
      res_o.is_extended = state_i.status_latch[SlExt];
      res_o.frame_id    = state_i.status_latch[SlExt] ? state_i.id_accum[31:3]
                                                      : {18'd0, state_i.id_accum[15:5]};
      res_o.is_remote   = state_i.status_latch[SlRtr];
      res_o.data_length = (sl_len > 4'd8) ? 4'd8 : sl_len;
      res_o.payload     = nxt.payload;
      res_o.stamp       = nxt.stamp;
      res_o.stamp_valid = 1'b1;
    end else if (head_done && state_i.func_code == FnBusEvent && bev.ev) begin
      res_valid_o       = 1'b1;
      res_o.kind        = bev.kind;
      res_o.stamp       = nxt.stamp;
      res_o.stamp_valid = state_i.status_latch[SlTs];
    end
  end

endmodule

### rtl/crdf_outq.sv
module crdf_outq import crdf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  crdf_result_t data_i,
  output logic         full_o,
  output logic         valid_o,
  input  logic         ready_i,
  output crdf_result_t data_o
);

  logic         main_v_q, main_v_d;
  logic         skid_v_q, skid_v_d;
  crdf_result_t main_q, main_d;
  crdf_result_t skid_q, skid_d;
  logic         pop;

  assign pop     = main_v_q && ready_i;
  assign full_o  = skid_v_q;
  assign valid_o = main_v_q;
  assign data_o  = main_q;

  always_comb begin
    main_v_d = main_v_q;
    skid_v_d = skid_v_q;
    main_d   = main_q;
    skid_d   = skid_q;
    if (pop) begin
      if (skid_v_q) begin
        main_d   = skid_q;
        skid_v_d = 1'b0;
      end else if (push_i) begin
        main_d = data_i;
      end else begin
        main_v_d = 1'b0;
      end
    end else if (push_i) begin
      if (!main_v_q) begin
        main_d   = data_i;
        main_v_d = 1'b1;
      end else begin
        skid_d   = data_i;
        skid_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

### tb/can_usb_rx_record_deframer_tb.sv
`timescale 1ns / 100ps

module can_usb_rx_record_deframer_tb;
  import crdf_pkg::*;

  localparam logic [7:0] SL_TS  = 8'h80;
  localparam logic [7:0] SL_INT = 8'h40;
  localparam logic [7:0] SL_EXT = 8'h20;
  localparam logic [7:0] SL_RTR = 8'h10;

  localparam logic [7:0] FN_BUS_EVENT = 8'd1;
  localparam logic [7:0] FN_SKIP2     = 8'd2;
  localparam logic [7:0] FN_SKIP1     = 8'd3;
  localparam logic [7:0] FN_STAMP     = 8'd4;

  localparam logic [7:0] ERR_WARN    = 8'h04;
  localparam logic [7:0] ERR_PASSIVE = 8'h08;
  localparam logic [7:0] ERR_BUSOFF  = 8'h10;
  localparam logic [7:0] ERR_OVR     = 8'h42;
  localparam logic [7:0] ERR_QOVR    = 8'h40;

  // {first_byte, last_byte}
  localparam logic [1:0] MID  = 2'b00;
  localparam logic [1:0] TAIL = 2'b01;
  localparam logic [1:0] HEAD = 2'b10;
  localparam logic [1:0] LONE = 2'b11;

  localparam logic [2:0] PIN_NONE       = 3'd0;
  localparam logic [2:0] PIN_FMT_ACTIVE = 3'd1;
  localparam logic [2:0] PIN_FRAME      = 3'd2;
  localparam logic [2:0] PIN_WARN       = 3'd3;
  localparam logic [2:0] PIN_FMT_WARN   = 3'd4;

  localparam int NUM_ROWS = 28;
  localparam logic [12:0] DIRECTED_ROWS [0:NUM_ROWS-1] = '{
    {8'h00, LONE, PIN_FMT_ACTIVE},
    {8'h00, HEAD, PIN_NONE},
    {8'h02, MID,  PIN_NONE},
    {8'h02, MID,  PIN_NONE},
    {8'hE0, MID,  PIN_NONE},
    {8'hFF, MID,  PIN_NONE},
    {8'h34, MID,  PIN_NONE},
    {8'h12, MID,  PIN_NONE},
    {8'hAA, MID,  PIN_NONE},
    {8'h55, MID,  PIN_FRAME},
    {8'h3F, MID,  PIN_NONE},
    {8'hFF, MID,  PIN_NONE},
    {8'hFF, MID,  PIN_NONE},
    {8'hFF, MID,  PIN_NONE},
    {8'hFF, MID,  PIN_NONE},
    {8'h00, MID,  PIN_NONE},
    {8'hA5, MID,  PIN_NONE},
    {8'h00, HEAD, PIN_NONE},
    {8'h01, MID,  PIN_NONE},
    {8'h40, MID,  PIN_NONE},
    {8'h01, MID,  PIN_NONE},
    {8'h04, MID,  PIN_WARN},
    {8'h00, HEAD, PIN_NONE},
    {8'hFF, MID,  PIN_NONE},
    {8'h08, MID,  PIN_NONE},
    {8'h00, HEAD, PIN_NONE},
    {8'hFF, MID,  PIN_NONE},
    {8'h48, TAIL, PIN_FMT_WARN}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [7:0]          s_axis_tdata_i = 8'd0;   // in_byte
  logic                s_axis_tuser_i = 1'b0;   // first_byte
  logic                s_axis_tlast_i = 1'b0;   // last_byte
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  // frame_id, is_extended, is_remote, data_length, payload, stamp, stamp_valid,
  // bus_state, zero pad
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic [1:0]          m_axis_tuser_o;          // record_kind

  logic [2:0]   pin_q = PIN_NONE;
  crdf_result_t pinned_res [1:4];

  int send_idle_pct = 0;
  int sink_stall_pct = 0;
  bit bus_off_ok = 1'b0;
  bit stamp_ok = 1'b0;
  int buffers_made = 0;
  int bytes_sent = 0;
  int records_checked = 0;
  int mismatches = 0;
  int kinds_seen [4] = '{0, 0, 0, 0};

  crdf_result_t pending_records [$];

  // decoder mirror
  crdf_phase_e  ph = PH_IDLE;
  logic [7:0]   fcnt = '0, rec_total = '0, rec_idx = '0, data_idx = '0;
  logic [7:0]   sl = '0, fn_code = '0, fn_arg = '0, last_low = '0;
  logic [15:0]  stamp_q = '0;
  logic [31:0]  id_q = '0;
  logic [63:0]  pay_q = '0;
  crdf_bus_e    bus_q = BUS_ACTIVE;
  logic         synced_q = 1'b0;
  logic         step_hit;
  crdf_result_t step_out;

  can_usb_rx_record_deframer uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic crdf_result_t blank_result();
    crdf_result_t r;
    r = '0;
    r.bus_state = bus_q;
    return r;
  endfunction

  function automatic logic [7:0] body_bytes(logic [7:0] fc, logic [7:0] s);
    if (fc == FN_SKIP2) return 8'd2;
    if (fc == FN_SKIP1) return 8'd1;
    if (fc == FN_STAMP) return (s[3:0] < 4'd2) ? 8'd2 : {4'd0, s[3:0]};
    return {4'd0, s[3:0]};
  endfunction

  function automatic logic stamp_byte(logic [7:0] b, logic wide);
    if (wide) begin
      if (fcnt == 0) begin
        stamp_q[7:0] = b;
        fcnt = 8'd1;
        return 1'b0;
      end
      stamp_q[15:8] = b;
      last_low = stamp_q[7:0];
      return 1'b1;
    end
    if (b < last_low) stamp_q = stamp_q + 16'h0100;
    stamp_q[7:0] = b;
    last_low = b;
    return 1'b1;
  endfunction

  function automatic int bus_step(logic [7:0] n);
    crdf_bus_e nxt;
    logic      ovf;
    nxt = bus_q;
    ovf = 1'b0;
    if (n == ERR_QOVR && !synced_q) return 0;
    if (bus_q == BUS_OFF) return 0;
    if (bus_q == BUS_ACTIVE && (n & ERR_WARN) != 0) begin
      nxt = BUS_WARNING;
    end else if (bus_q == BUS_ACTIVE || bus_q == BUS_WARNING) begin
      if ((n & ERR_PASSIVE) != 0) nxt = BUS_PASSIVE;
      else if ((n & ERR_BUSOFF) != 0) nxt = BUS_OFF;
      else if ((n & ERR_OVR) != 0) ovf = 1'b1;
      else if ((n & ERR_WARN) == 0) begin
        bus_q = BUS_ACTIVE;
        return 0;
      end
    end else begin
      if ((n & ERR_BUSOFF) != 0) nxt = BUS_OFF;
      else if ((n & ERR_WARN) != 0) nxt = BUS_WARNING;
      else if ((n & ERR_OVR) != 0) ovf = 1'b1;
      else if ((n & ERR_PASSIVE) == 0) begin
        bus_q = BUS_ACTIVE;
        return 0;
      end
    end
    if (ovf) return 2;
    if (nxt == bus_q) return 0;
    bus_q = nxt;
    return 1;
  endfunction

  task automatic close_record();
    rec_idx = rec_idx + 8'd1;
    ph = (rec_idx == rec_total) ? PH_IDLE : PH_SL;
  endtask

  task automatic data_frame();
    step_out = blank_result();
    step_out.kind = KIND_DATA;
    if ((sl & SL_EXT) != 0) begin
      step_out.frame_id = id_q[31:3];
      step_out.is_extended = 1'b1;
    end else begin
      step_out.frame_id = {18'd0, id_q[15:5]};
    end
    step_out.is_remote = ((sl & SL_RTR) != 0);
    step_out.data_length = (sl[3:0] > 4'd8) ? 4'd8 : sl[3:0];
    step_out.payload = pay_q;
    step_out.stamp = stamp_q;
    step_out.stamp_valid = 1'b1;
    step_hit = 1'b1;
    data_idx = data_idx + 8'd1;
    close_record();
  endtask

  task automatic status_head();
    int k;
    if (fn_code == FN_BUS_EVENT) begin
      k = bus_step(fn_arg);
      if (k != 0) begin
        step_out = blank_result();
        step_out.kind = (k == 1) ? KIND_STATE : KIND_OVERFLOW;
        step_out.stamp = stamp_q;
        step_out.stamp_valid = ((sl & SL_TS) != 0);
        step_hit = 1'b1;
      end
    end
    fcnt = '0;
    if (body_bytes(fn_code, sl) == 0) close_record();
    else ph = PH_SBODY;
  endtask

  task automatic predict_byte(logic [7:0] b, logic first, logic last);
    logic ferr;
    ferr = 1'b0;
    step_hit = 1'b0;
    step_out = '0;
    if (first) begin
      rec_idx = '0;
      data_idx = '0;
      stamp_q = '0;
      last_low = '0;
      fcnt = '0;
      ph = PH_HDR1;
      ferr = last;
    end else begin
      case (ph)
        PH_HDR1: begin
          rec_total = b;
          ph = (b == 0) ? PH_IDLE : PH_SL;
          ferr = last;
        end
        PH_SL: begin
          sl = b;
          fcnt = '0;
          if ((b & SL_INT) != 0) begin
            ph = PH_SF;
          end else begin
            id_q = '0;
            ph = PH_DID;
          end
        end
        PH_DID: begin
          id_q = id_q | ({24'd0, b} << (8 * fcnt[1:0]));
          fcnt = fcnt + 8'd1;
          if (fcnt == (((sl & SL_EXT) != 0) ? 8'd4 : 8'd2)) begin
            fcnt = '0;
            ph = PH_DTS;
          end
        end
        PH_DTS: begin
          if (stamp_byte(b, data_idx == 0)) begin
            pay_q = '0;
            fcnt = '0;
            if ((sl & SL_RTR) != 0 || sl[3:0] == 0) data_frame();
            else ph = PH_DPAY;
          end
        end
        PH_DPAY: begin
          if (fcnt < 8) pay_q = pay_q | ({56'd0, b} << (8 * fcnt));
          fcnt = fcnt + 8'd1;
          if (fcnt == {4'd0, sl[3:0]}) data_frame();
        end
        PH_SF: begin
          fn_code = b;
          ph = PH_SN;
        end
        PH_SN: begin
          fn_arg = b;
          fcnt = '0;
          if ((sl & SL_TS) != 0) ph = PH_STS;
          else status_head();
        end
        PH_STS: begin
          if (stamp_byte(b, rec_idx == 0)) status_head();
        end
        PH_SBODY: begin
          if (fn_code == FN_STAMP && fcnt < 2) begin
            if (fcnt == 0) begin
              stamp_q[7:0] = b;
            end else begin
              stamp_q[15:8] = b;
              synced_q = 1'b1;
            end
          end
          fcnt = fcnt + 8'd1;
          if (fcnt == body_bytes(fn_code, sl)) close_record();
        end
        default: ph = PH_IDLE;
      endcase
    end
    if (last) begin
      if (ph != PH_SL && ph != PH_IDLE && ph != PH_HDR1) ferr = 1'b1;
      ph = PH_IDLE;
    end
    if (ferr) begin
      step_out = blank_result();
      step_out.kind = KIND_FMT_ERR;
      step_hit = 1'b1;
    end
  endtask

  function automatic string describe(crdf_result_t r);
    return $sformatf("kind=%0d id=%h ext=%b rtr=%b dlc=%0d data=%h ts=%h tsv=%b bus=%0d",
                     r.kind, r.frame_id, r.is_extended, r.is_remote, r.data_length,
                     r.payload, r.stamp, r.stamp_valid, r.bus_state);
  endfunction

  task automatic check_record();
    crdf_result_t got, want;
    got.kind        = crdf_kind_e'(m_axis_tuser_o);
    got.frame_id    = m_axis_tdata_o[28:0];
    got.is_extended = m_axis_tdata_o[29];
    got.is_remote   = m_axis_tdata_o[30];
    got.data_length = m_axis_tdata_o[34:31];
    got.payload     = m_axis_tdata_o[98:35];
    got.stamp       = m_axis_tdata_o[114:99];
    got.stamp_valid = m_axis_tdata_o[115];
    got.bus_state   = crdf_bus_e'(m_axis_tdata_o[117:116]);
    if (pending_records.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("record with nothing pending: %s", describe(got));
    end else begin
      want = pending_records.pop_front();
      kinds_seen[want.kind]++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("record %0d mismatch", records_checked);
          $display("  exp %s", describe(want));
          $display("  got %s", describe(got));
        end
      end
      records_checked++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_byte(s_axis_tdata_i, s_axis_tuser_i, s_axis_tlast_i);
        if (pin_q != PIN_NONE) pending_records.push_back(pinned_res[pin_q]);
        else if (step_hit) pending_records.push_back(step_out);
      end
      if (m_axis_tvalid_o && m_axis_tready_i) check_record();
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic [1:0] pos, input logic [2:0] pin);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= b;
    {s_axis_tuser_i, s_axis_tlast_i} <= pos;
    pin_q <= pin;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  function automatic logic [7:0] pick_err_flags();
    logic [7:0] v;
    v = 8'($urandom) & 8'($urandom);
    if ($urandom_range(4) == 0) v = ERR_QOVR;
    if (!bus_off_ok) v = v & ~ERR_BUSOFF;
    return v;
  endfunction

  task automatic gen_buffer();
    logic [7:0] q [$];
    logic [7:0] s, fc, n;
    int         recs, len, mode, cut;
    bit         data_seen, with_last;
    data_seen = 1'b0;
    with_last = 1'b1;
    q.push_back(8'($urandom));
    recs = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 5);
    q.push_back(8'(recs));
    for (int i = 0; i < recs; i++) begin
      if ($urandom_range(9) < 6) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
        s = {1'($urandom), 1'b0, 1'($urandom), ($urandom_range(4) == 0), 4'(len)};
        q.push_back(s);
        repeat (((s & SL_EXT) != 0) ? 4 : 2) q.push_back(8'($urandom));
        q.push_back(8'($urandom));
        if (!data_seen) q.push_back(8'($urandom));
        data_seen = 1'b1;
        if ((s & SL_RTR) == 0) repeat (len) q.push_back(8'($urandom));
      end else begin
        len = ($urandom_range(3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
        s = {1'($urandom), 1'b1, 2'($urandom), 4'(len)};
        mode = $urandom_range(9);
        case (mode)
          5: fc = FN_SKIP2;
          6: fc = FN_SKIP1;
          7: fc = stamp_ok ? FN_STAMP : FN_BUS_EVENT;
          8: fc = 8'd0;
          9: fc = 8'($urandom_range(5, 255));
          default: fc = FN_BUS_EVENT;
        endcase
        n = (fc == FN_BUS_EVENT) ? pick_err_flags() : 8'($urandom);
        q.push_back(s);
        q.push_back(fc);
        q.push_back(n);
        if ((s & SL_TS) != 0) repeat ((i == 0) ? 2 : 1) q.push_back(8'($urandom));
        repeat (body_bytes(fc, s)) q.push_back(8'($urandom));
      end
    end
    mode = $urandom_range(19);
    if (mode >= 5 && mode <= 7) repeat ($urandom_range(1, 3)) q.push_back(8'($urandom));
    if (mode == 8) q[1] = q[1] + 8'($urandom_range(1, 3));
    if (mode < 5 && q.size() > 1) begin
      cut = $urandom_range(1, q.size() - 1);
      while (q.size() > cut) void'(q.pop_back());
      with_last = (mode < 3);
    end
    buffers_made++;
    stamp_ok = (buffers_made >= 12);
    for (int j = 0; j < q.size(); j++)
      send_byte(q[j], {j == 0, with_last && j == q.size() - 1}, PIN_NONE);
  endtask

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [7:0] b;
    logic [1:0] pos;
    logic [2:0] pin;
    int         phase_start;

    pinned_res[PIN_FMT_ACTIVE] = '0;
    pinned_res[PIN_FMT_ACTIVE].kind = KIND_FMT_ERR;
    pinned_res[PIN_FMT_ACTIVE].bus_state = BUS_ACTIVE;
    pinned_res[PIN_FRAME] = '0;
    pinned_res[PIN_FRAME].kind = KIND_DATA;
    pinned_res[PIN_FRAME].frame_id = 29'h7FF;
    pinned_res[PIN_FRAME].data_length = 4'd2;
    pinned_res[PIN_FRAME].payload = 64'h55AA;
    pinned_res[PIN_FRAME].stamp = 16'h1234;
    pinned_res[PIN_FRAME].stamp_valid = 1'b1;
    pinned_res[PIN_FRAME].bus_state = BUS_ACTIVE;
    pinned_res[PIN_WARN] = '0;
    pinned_res[PIN_WARN].kind = KIND_STATE;
    pinned_res[PIN_WARN].bus_state = BUS_WARNING;
    pinned_res[PIN_FMT_WARN] = '0;
    pinned_res[PIN_FMT_WARN].kind = KIND_FMT_ERR;
    pinned_res[PIN_FMT_WARN].bus_state = BUS_WARNING;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NUM_ROWS; i++) begin
      {b, pos, pin} = DIRECTED_ROWS[i];
      send_byte(b, pos, pin);
    end

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin send_idle_pct = 45; sink_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  sink_stall_pct = 45; end
        default: begin send_idle_pct = 9; sink_stall_pct = 9; end
      endcase
      bus_off_ok = (p == 3);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 450) begin
        if ($urandom_range(19) == 0)
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 2'($urandom), PIN_NONE);
        else
          gen_buffer();
      end
    end
    s_axis_tvalid_i <= 1'b0;

    while (pending_records.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("run covered %0d bytes in %0d generated buffers, %0d records checked",
             bytes_sent, buffers_made, records_checked);
    $display("  frames %0d, state changes %0d, overflows %0d, format errors %0d",
             kinds_seen[KIND_DATA], kinds_seen[KIND_STATE], kinds_seen[KIND_OVERFLOW],
             kinds_seen[KIND_FMT_ERR]);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
rtl/crdf_pkg.sv
rtl/crdf_step.sv
rtl/crdf_outq.sv
rtl/can_usb_rx_record_deframer.sv
tb/can_usb_rx_record_deframer_tb.sv
